### sv/rrts_pkg.sv
// ----------------------------------------------------------------------------
// rrts_pkg: shared types and constants of the round-robin task scheduler
// Task slot count, field widths, request and task-state codes, and the
// command structs passed from the event decoder to the ready queue and table.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  // slot count is bounded by the 4-bit task_id field
  localparam int NUM_TASKS = 16;
  localparam int TASK_W    = $clog2(NUM_TASKS);
  localparam int COUNT_W   = TASK_W + 1;
  localparam int ID_W      = 4;
  localparam int REQ_W     = 3;
  localparam int QUANT_W   = 16;
  localparam int TIME_W    = 32;

  localparam logic [TASK_W-1:0]  IDLE_SLOT     = '0;
  localparam logic [COUNT_W-1:0] FIFO_FULL     = COUNT_W'(NUM_TASKS);
  localparam logic [ID_W:0]      TASK_LIMIT    = (ID_W + 1)'(NUM_TASKS);
  localparam logic [QUANT_W-1:0] QUANTUM_RESET = 16'd100;

  typedef enum logic [1:0] {
    ST_RUN     = 2'd0,
    ST_QUEUED  = 2'd1,
    ST_WAITING = 2'd2,
    ST_FREE    = 2'd3
  } task_state_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK    = 3'd0,
    REQ_PREEMPT = 3'd1,
    REQ_BLOCK   = 3'd2,
    REQ_EXIT    = 3'd3,
    REQ_ADMIT   = 3'd4,
    REQ_QUANTUM = 3'd5,
    REQ_QUERY   = 3'd6
  } req_t;

  typedef struct packed {
    logic              push;
    logic [TASK_W-1:0] push_task;
    logic              pop;
  } fifo_cmd_t;

  typedef struct packed {
    logic               tick;
    logic               charge;
    logic               leave;
    task_state_t        leave_state;
    logic               dispatch;
    logic [TASK_W-1:0]  next_task;
    logic               admit;
    logic               admit_clear;
    logic               quantum_wr;
    logic               load_default;
    logic [QUANT_W-1:0] quantum;
  } table_cmd_t;

  // a zero slice length is taken as one tick
  function automatic logic [QUANT_W-1:0] clamp_quantum(input logic [QUANT_W-1:0] v);
    logic [QUANT_W-1:0] q;
    q = (v == '0) ? QUANT_W'(1) : v;
    return q;
  endfunction

endpackage

`default_nettype wire

### sv/rrts_fifo.sv
// ----------------------------------------------------------------------------
// rrts_fifo: ready queue
// Circular queue of task slot numbers with head pointer and fill count; one
// push and one pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_fifo (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire rrts_pkg::fifo_cmd_t            cmd,
  output logic [rrts_pkg::TASK_W-1:0]         head_task,
  output logic [rrts_pkg::COUNT_W-1:0]        count
);

  logic [rrts_pkg::TASK_W-1:0]  slots [rrts_pkg::NUM_TASKS];
  logic [rrts_pkg::TASK_W-1:0]  head;
  logic [rrts_pkg::TASK_W-1:0]  head_next;
  logic [rrts_pkg::TASK_W-1:0]  tail;
  logic [rrts_pkg::COUNT_W-1:0] tail_sum;
  logic [rrts_pkg::COUNT_W-1:0] count_next;

  always_comb begin
    tail_sum = {1'b0, head} + count;
    if (tail_sum >= rrts_pkg::FIFO_FULL) begin
      tail = rrts_pkg::TASK_W'(tail_sum - rrts_pkg::FIFO_FULL);
    end else begin
      tail = tail_sum[rrts_pkg::TASK_W-1:0];
    end
    if (head == rrts_pkg::TASK_W'(rrts_pkg::NUM_TASKS - 1)) begin
      head_next = '0;
    end else begin
      head_next = head + 1'b1;
    end
    count_next = count;
    if (cmd.push && !cmd.pop) begin
      count_next = count + 1'b1;
    end else if (!cmd.push && cmd.pop) begin
      count_next = count - 1'b1;
    end
  end

  assign head_task = slots[head];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      slots[tail] <= cmd.push_task;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (cmd.pop) begin
        head <= head_next;
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

### sv/rrts_table.sv
// ----------------------------------------------------------------------------
// rrts_table: per-task state, quantum and tick statistics
// Each array has one read address chosen by the event; the running task's
// last mark is also kept in a register so that a switch needs one mark read.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_table (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rrts_pkg::table_cmd_t          cmd,
  input  wire logic [rrts_pkg::TASK_W-1:0]   cur_task,
  input  wire logic [rrts_pkg::TASK_W-1:0]   sel_task,
  input  wire logic [rrts_pkg::TIME_W-1:0]   now,
  output rrts_pkg::task_state_t              sel_state,
  output logic [rrts_pkg::QUANT_W-1:0]       quantum_rd,
  output logic [rrts_pkg::QUANT_W-1:0]       slice_rd,
  output logic [rrts_pkg::TIME_W-1:0]        ready_rd,
  output logic [rrts_pkg::TIME_W-1:0]        system_rd,
  output logic [rrts_pkg::TIME_W-1:0]        dispatch_rd
);

  rrts_pkg::task_state_t        state_mem   [rrts_pkg::NUM_TASKS];
  logic [rrts_pkg::QUANT_W-1:0] quantum_mem [rrts_pkg::NUM_TASKS];
  logic [rrts_pkg::QUANT_W-1:0] slice_mem   [rrts_pkg::NUM_TASKS];
  logic [rrts_pkg::TIME_W-1:0]  ready_mem   [rrts_pkg::NUM_TASKS];
  logic [rrts_pkg::TIME_W-1:0]  system_mem  [rrts_pkg::NUM_TASKS];
  logic [rrts_pkg::TIME_W-1:0]  mark_mem    [rrts_pkg::NUM_TASKS];
  logic [rrts_pkg::TIME_W-1:0]  disp_mem    [rrts_pkg::NUM_TASKS];
  logic [rrts_pkg::TIME_W-1:0]  cur_mark;

  logic [rrts_pkg::TASK_W-1:0]  nq_addr;
  logic [rrts_pkg::TASK_W-1:0]  sys_addr;
  logic [rrts_pkg::TASK_W-1:0]  slc_addr;
  logic [rrts_pkg::TIME_W-1:0]  run_delta;
  logic [rrts_pkg::TIME_W-1:0]  wait_delta;
  logic [rrts_pkg::TIME_W-1:0]  ready_new;
  logic [rrts_pkg::QUANT_W-1:0] slice_dec;

  always_comb begin
    nq_addr  = cmd.dispatch ? cmd.next_task : sel_task;
    sys_addr = cmd.charge ? cur_task : sel_task;
    slc_addr = cmd.tick ? cur_task : sel_task;

    sel_state   = state_mem[sel_task];
    quantum_rd  = quantum_mem[nq_addr];
    ready_rd    = ready_mem[nq_addr];
    dispatch_rd = disp_mem[nq_addr];
    system_rd   = system_mem[sys_addr];
    slice_rd    = slice_mem[slc_addr];

    run_delta = now - cur_mark;
    // a task preempted and dispatched again in the same event waited no time
    if (cmd.charge && (cmd.next_task == cur_task)) begin
      wait_delta = '0;
    end else begin
      wait_delta = now - mark_mem[nq_addr];
    end
    ready_new = ready_rd + wait_delta;
    slice_dec = (slice_rd == '0) ? '0 : slice_rd - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rrts_pkg::NUM_TASKS; i++) begin
        state_mem[i]   <= (rrts_pkg::TASK_W'(i) == rrts_pkg::IDLE_SLOT) ?
                          rrts_pkg::ST_RUN : rrts_pkg::ST_FREE;
        quantum_mem[i] <= rrts_pkg::QUANTUM_RESET;
        slice_mem[i]   <= '0;
        ready_mem[i]   <= '0;
        system_mem[i]  <= '0;
        mark_mem[i]    <= '0;
        disp_mem[i]    <= '0;
      end
      cur_mark <= '0;
    end else begin
      for (int i = 0; i < rrts_pkg::NUM_TASKS; i++) begin
        if (cmd.load_default) begin
          quantum_mem[i] <= cmd.quantum;
        end else if (cmd.quantum_wr && (rrts_pkg::TASK_W'(i) == sel_task)) begin
          quantum_mem[i] <= cmd.quantum;
        end

        if (cmd.charge && (rrts_pkg::TASK_W'(i) == cur_task)) begin
          system_mem[i] <= system_rd + run_delta;
        end

        if (cmd.dispatch && (rrts_pkg::TASK_W'(i) == cmd.next_task)) begin
          state_mem[i] <= rrts_pkg::ST_RUN;
          ready_mem[i] <= ready_new;
          mark_mem[i]  <= now;
          disp_mem[i]  <= dispatch_rd + 1'b1;
          slice_mem[i] <= quantum_rd;
        end else if (cmd.admit && (rrts_pkg::TASK_W'(i) == sel_task)) begin
          state_mem[i] <= rrts_pkg::ST_QUEUED;
          mark_mem[i]  <= now;
          if (cmd.admit_clear) begin
            ready_mem[i]  <= '0;
            system_mem[i] <= '0;
            disp_mem[i]   <= '0;
            slice_mem[i]  <= quantum_rd;
          end
        end else if (rrts_pkg::TASK_W'(i) == cur_task) begin
          if (cmd.leave) begin
            state_mem[i] <= cmd.leave_state;
          end
          if (cmd.charge) begin
            mark_mem[i] <= now;
          end
          if (cmd.tick) begin
            slice_mem[i] <= slice_dec;
          end
        end
      end
      if (cmd.dispatch) begin
        cur_mark <= now;
      end
    end
  end

endmodule

`default_nettype wire

### sv/round_robin_task_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_task_scheduler: round-robin scheduler with per-task quantum
// Event decoder, running-task registers and result register around the
// ready queue and the per-task table.
// ----------------------------------------------------------------------------
// An event is taken when start is high and busy is low; its result appears
// on the result ports one cycle later with done high for exactly that cycle,
// and must be captured then since the receiver cannot stall the block. Every
// event is handled in a single pass from the input ports through the queue
// and table lookups into the result register, so one event can be taken in
// every cycle; busy is high only in the cycle that follows reset. The
// quantum of every task slot and the running slice can be loaded from
// cfg_data when no event is presented; cfg_ready is low while start is high.
`default_nettype none

module round_robin_task_scheduler (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [rrts_pkg::REQ_W-1:0]     req_type,
  input  wire logic [rrts_pkg::ID_W-1:0]      task_id,
  input  wire logic [rrts_pkg::QUANT_W-1:0]   quantum_value,
  input  wire logic [rrts_pkg::TIME_W-1:0]    now_ticks,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [rrts_pkg::QUANT_W-1:0]   cfg_data,
  output logic                                done,
  output logic [rrts_pkg::ID_W-1:0]           running_task,
  output logic                                switched,
  output logic                                need_resched,
  output logic [1:0]                          queried_state,
  output logic [rrts_pkg::TIME_W-1:0]         ready_time,
  output logic [rrts_pkg::TIME_W-1:0]         system_time,
  output logic [rrts_pkg::TIME_W-1:0]         dispatch_count,
  output logic [rrts_pkg::QUANT_W-1:0]        slice_remaining,
  output logic                                error_flag
);

  logic [rrts_pkg::TASK_W-1:0]  current_task;
  logic [rrts_pkg::TASK_W-1:0]  current_task_next;
  logic [rrts_pkg::QUANT_W-1:0] slice_left;
  logic [rrts_pkg::QUANT_W-1:0] slice_left_next;

  logic                         accept;
  logic                         idok;
  logic                         do_dispatch;
  logic                         sw;
  logic                         err;
  logic                         query;
  logic [rrts_pkg::TASK_W-1:0]  sel_task;

  rrts_pkg::fifo_cmd_t          fcmd;
  rrts_pkg::table_cmd_t         tcmd;
  logic [rrts_pkg::TASK_W-1:0]  head_task;
  logic [rrts_pkg::COUNT_W-1:0] q_count;

  rrts_pkg::task_state_t        sel_state;
  logic [rrts_pkg::QUANT_W-1:0] quantum_rd;
  logic [rrts_pkg::QUANT_W-1:0] slice_rd;
  logic [rrts_pkg::TIME_W-1:0]  ready_rd;
  logic [rrts_pkg::TIME_W-1:0]  system_rd;
  logic [rrts_pkg::TIME_W-1:0]  dispatch_rd;

  // a config beat never shares a cycle with an event
  assign cfg_ready = !start;
  assign accept    = start && !busy;
  assign sel_task  = task_id[rrts_pkg::TASK_W-1:0];
  assign idok      = ({1'b0, task_id} < rrts_pkg::TASK_LIMIT);

  always_comb begin
    fcmd              = '0;
    tcmd              = '0;
    tcmd.quantum      = rrts_pkg::clamp_quantum(quantum_value);
    do_dispatch       = 1'b0;
    sw                = 1'b0;
    err               = 1'b0;
    query             = 1'b0;
    current_task_next = current_task;
    slice_left_next   = slice_left;

    if (cfg_valid && cfg_ready) begin
      tcmd.load_default = 1'b1;
      tcmd.quantum      = rrts_pkg::clamp_quantum(cfg_data);
      slice_left_next   = rrts_pkg::clamp_quantum(cfg_data);
    end else if (accept) begin
      case (rrts_pkg::req_t'(req_type))
        rrts_pkg::REQ_TICK: begin
          tcmd.tick       = 1'b1;
          slice_left_next = (slice_left == '0) ? '0 : slice_left - 1'b1;
        end
        rrts_pkg::REQ_PREEMPT: begin
          if ((current_task != rrts_pkg::IDLE_SLOT) && (q_count >= rrts_pkg::FIFO_FULL)) begin
            err = 1'b1;
          end else begin
            tcmd.charge      = 1'b1;
            tcmd.leave       = 1'b1;
            tcmd.leave_state = rrts_pkg::ST_QUEUED;
            fcmd.push        = (current_task != rrts_pkg::IDLE_SLOT);
            fcmd.push_task   = current_task;
            do_dispatch      = 1'b1;
          end
        end
        rrts_pkg::REQ_BLOCK, rrts_pkg::REQ_EXIT: begin
          if (current_task == rrts_pkg::IDLE_SLOT) begin
            err = 1'b1;
          end else begin
            tcmd.leave = 1'b1;
            if (rrts_pkg::req_t'(req_type) == rrts_pkg::REQ_BLOCK) begin
              tcmd.charge      = 1'b1;
              tcmd.leave_state = rrts_pkg::ST_WAITING;
            end else begin
              tcmd.leave_state = rrts_pkg::ST_FREE;
            end
            do_dispatch = 1'b1;
          end
        end
        rrts_pkg::REQ_ADMIT: begin
          if (!idok || (sel_task == rrts_pkg::IDLE_SLOT) ||
              (q_count >= rrts_pkg::FIFO_FULL) ||
              !(sel_state inside {rrts_pkg::ST_FREE, rrts_pkg::ST_WAITING})) begin
            err = 1'b1;
          end else begin
            tcmd.admit       = 1'b1;
            tcmd.admit_clear = (sel_state == rrts_pkg::ST_FREE);
            fcmd.push        = 1'b1;
            fcmd.push_task   = sel_task;
          end
        end
        rrts_pkg::REQ_QUANTUM: begin
          if (!idok) begin
            err = 1'b1;
          end else begin
            tcmd.quantum_wr = 1'b1;
          end
        end
        rrts_pkg::REQ_QUERY: begin
          if (!idok) begin
            err = 1'b1;
          end else begin
            query = 1'b1;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase

      // head of queue, else the task pushed this beat, else idle
      if (do_dispatch) begin
        sw            = 1'b1;
        tcmd.dispatch = 1'b1;
        fcmd.pop      = (q_count != '0) || fcmd.push;
        if (q_count != '0) begin
          tcmd.next_task = head_task;
        end else if (fcmd.push) begin
          tcmd.next_task = fcmd.push_task;
        end else begin
          tcmd.next_task = rrts_pkg::IDLE_SLOT;
        end
        current_task_next = tcmd.next_task;
        slice_left_next   = quantum_rd;
      end
    end
  end

  rrts_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .cmd       (fcmd),
    .head_task (head_task),
    .count     (q_count)
  );

  rrts_table u_table (
    .clk         (clk),
    .rst         (rst),
    .cmd         (tcmd),
    .cur_task    (current_task),
    .sel_task    (sel_task),
    .now         (now_ticks),
    .sel_state   (sel_state),
    .quantum_rd  (quantum_rd),
    .slice_rd    (slice_rd),
    .ready_rd    (ready_rd),
    .system_rd   (system_rd),
    .dispatch_rd (dispatch_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b1;
      done         <= 1'b0;
      current_task <= rrts_pkg::IDLE_SLOT;
      slice_left   <= rrts_pkg::QUANTUM_RESET;
    end else begin
      busy         <= 1'b0;
      done         <= accept;
      current_task <= current_task_next;
      slice_left   <= slice_left_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      running_task    <= rrts_pkg::ID_W'(current_task_next);
      switched        <= sw;
      need_resched    <= (slice_left_next == '0);
      error_flag      <= err;
      queried_state   <= query ? sel_state : 2'b00;
      ready_time      <= query ? ready_rd : '0;
      system_time     <= query ? system_rd : '0;
      dispatch_count  <= query ? dispatch_rd : '0;
      slice_remaining <= query ? slice_rd : '0;
    end
  end

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result beat without an accepted event");

  a_switch_clean: assert property (@(posedge clk) disable iff (rst)
    (done && switched) |-> (!error_flag && !need_resched))
    else $error("dispatch reported with error or empty slice");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= rrts_pkg::FIFO_FULL)
    else $error("ready queue count beyond slot count");

endmodule

`default_nettype wire
